FILE: src/rtttl_pkg.sv
// Package for the RTTTL melody parser: codes, widths, tables and character helpers.
package rtttl_pkg;

    localparam int unsigned ChW      = 8;
    localparam int unsigned NumW     = 16;
    localparam int unsigned OctW     = 4;
    localparam int unsigned FreqW    = 15;
    localparam int unsigned DivW     = 18;
    localparam int unsigned DivCntW  = 5;
    localparam logic [DivCntW-1:0] DivSteps = DivCntW'(DivW);
    localparam logic [DivW-1:0]    MsPerMinute4 = DivW'(240000);
    localparam logic [FreqW-1:0]   FreqMax = FreqW'(20000);

    localparam logic [NumW-1:0] DefDuration = NumW'(4);
    localparam logic [OctW-1:0] DefOctave   = OctW'(6);
    localparam logic [NumW-1:0] DefTempo    = NumW'(140);

    // Sections
    localparam logic [1:0] SEC_NAME   = 2'd0;
    localparam logic [1:0] SEC_HEADER = 2'd1;
    localparam logic [1:0] SEC_NOTES  = 2'd2;

    // Header phases
    localparam logic [2:0] HP_KEY   = 3'd0;
    localparam logic [2:0] HP_EQ    = 3'd1;
    localparam logic [2:0] HP_VALUE = 3'd2;
    localparam logic [2:0] HP_IN    = 3'd3;
    localparam logic [2:0] HP_SKIP  = 3'd4;

    // Note phases
    localparam logic [2:0] NP_DUR    = 3'd0;
    localparam logic [2:0] NP_DURNUM = 3'd1;
    localparam logic [2:0] NP_SHARP  = 3'd3;
    localparam logic [2:0] NP_DOT    = 3'd4;
    localparam logic [2:0] NP_OCT    = 3'd5;
    localparam logic [2:0] NP_TDOT   = 3'd6;
    localparam logic [2:0] NP_SKIP   = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_TONE  = 2'd0;
    localparam logic [1:0] KIND_PAUSE = 2'd1;
    localparam logic [1:0] KIND_OK    = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    localparam logic [2:0] LETTER_P = 3'd7;

    // Characters
    localparam logic [ChW-1:0] CH_NUL   = 8'h00;
    localparam logic [ChW-1:0] CH_COLON = 8'h3A;
    localparam logic [ChW-1:0] CH_COMMA = 8'h2C;
    localparam logic [ChW-1:0] CH_EQ    = 8'h3D;
    localparam logic [ChW-1:0] CH_HASH  = 8'h23;
    localparam logic [ChW-1:0] CH_DOT   = 8'h2E;
    localparam logic [ChW-1:0] CH_SPACE = 8'h20;
    localparam logic [ChW-1:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic           valid;
        logic [2:0]     code;
    } letter_t;

    function automatic logic is_space(input logic [ChW-1:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [ChW-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [ChW-1:0] to_lower(input logic [ChW-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // Append a decimal digit, saturating at the top of the range
    function automatic logic [NumW-1:0] add_digit(input logic [NumW-1:0] v,
                                                  input logic [ChW-1:0] c);
        logic [NumW+3:0] r;
        logic [ChW-1:0]  d;
        d = c - CH_ZERO;
        r = {v, 3'b000} + {2'b00, v, 1'b0} + {{(NumW-4){1'b0}}, d};
        return (r > (NumW+4)'(65535)) ? {NumW{1'b1}} : r[NumW-1:0];
    endfunction

    function automatic letter_t letter_code(input logic [ChW-1:0] c);
        letter_t l;
        l.valid = 1'b1;
        case (to_lower(c))
            8'h63:   l.code = 3'd0;
            8'h64:   l.code = 3'd1;
            8'h65:   l.code = 3'd2;
            8'h66:   l.code = 3'd3;
            8'h67:   l.code = 3'd4;
            8'h61:   l.code = 3'd5;
            8'h62:   l.code = 3'd6;
            8'h70:   l.code = LETTER_P;
            default: begin
                l.valid = 1'b0;
                l.code  = 3'd0;
            end
        endcase
        return l;
    endfunction

    function automatic logic [3:0] letter_semitone(input logic [2:0] l);
        case (l)
            3'd0:    return 4'd0;
            3'd1:    return 4'd2;
            3'd2:    return 4'd4;
            3'd3:    return 4'd5;
            3'd4:    return 4'd7;
            3'd5:    return 4'd9;
            3'd6:    return 4'd11;
            default: return 4'd0;
        endcase
    endfunction

    // Octave-4 frequencies by semitone
    function automatic logic [8:0] base_freq(input logic [3:0] s);
        case (s)
            4'd0:    return 9'd262;
            4'd1:    return 9'd277;
            4'd2:    return 9'd294;
            4'd3:    return 9'd311;
            4'd4:    return 9'd330;
            4'd5:    return 9'd349;
            4'd6:    return 9'd370;
            4'd7:    return 9'd392;
            4'd8:    return 9'd415;
            4'd9:    return 9'd440;
            4'd10:   return 9'd466;
            4'd11:   return 9'd494;
            default: return 9'd262;
        endcase
    endfunction

endpackage

FILE: src/rtttl_melody_parser_core.sv
// RTTTL melody parser: character parser, shared divider sequencer and result register.
// A character that ends no note is taken in S_IDLE; a finish character then loads its result in S_PUTF.
// A note end runs two passes of the shared restoring divider (240000/bpm, then /duration)
// in S_DIV1 and S_DIV2, adds one extension per applied dot in S_DOTS, then loads the
// result in S_PUTN when the slot is free, then S_PUTF for a finish result that follows the note.
// Throughput: 1 character per cycle while in S_IDLE; a note end or finish character holds s_ready low.
// Reset: aresetn synchronous, active low; parser to its start state, note_gap_reg to 0.
module rtttl_melody_parser_core
    import rtttl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ChW-1:0]       s_ch,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [FreqW-1:0]     m_frequency_hz,
    output logic [NumW-1:0]      m_tone_ms,
    output logic [NumW-1:0]      m_gap_ms,
    output logic                 m_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_DOTS = 6'b001000,
        S_PUTN = 6'b010000,
        S_PUTF = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Parser state
    logic [1:0]       section_reg, section_next;
    logic [2:0]       header_phase_reg, header_phase_next;
    logic [ChW-1:0]   header_key_reg, header_key_next;
    logic [NumW-1:0]  number_value_reg, number_value_next;
    logic             number_seen_reg, number_seen_next;
    logic [NumW-1:0]  default_duration_reg, default_duration_next;
    logic [OctW-1:0]  default_octave_reg, default_octave_next;
    logic [NumW-1:0]  tempo_bpm_reg, tempo_bpm_next;
    logic [2:0]       note_phase_reg, note_phase_next;
    logic [NumW-1:0]  note_duration_reg, note_duration_next;
    logic [2:0]       note_letter_reg, note_letter_next;
    logic             note_sharp_reg, note_sharp_next;
    logic [7:0]       dot_count_reg, dot_count_next;
    logic [OctW-1:0]  note_octave_reg, note_octave_next;
    logic             error_seen_reg, error_seen_next;
    logic [NumW-1:0]  note_gap_reg;

    // Note snapshot and sequencer work registers
    logic [NumW-1:0]  w_dur_reg;
    logic [2:0]       w_letter_reg;
    logic             w_sharp_reg;
    logic [OctW-1:0]  w_oct_reg;
    logic [7:0]       w_dots_reg;
    logic             fin_pend_reg;
    logic             fin_fail_reg;
    logic [DivW-1:0]  div_num_reg;
    logic [NumW-1:0]  div_rem_reg;
    logic [NumW-1:0]  div_den_reg;
    logic [DivCntW-1:0] div_cnt_reg;
    logic [DivW:0]    ms_reg;
    logic [DivW-1:0]  ext_reg;

    // Result register
    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic [FreqW-1:0] m_freq_reg;
    logic [NumW-1:0]  m_tone_reg;
    logic [NumW-1:0]  m_gap_reg;
    logic             m_last_reg;

    logic             accept;
    logic             emit_note;
    logic             fail;
    logic             do_start;
    logic [2:0]       hp_cur;
    letter_t          lc;
    logic             slot_free;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign slot_free = !m_valid_reg || m_ready;

    // Parse one character
    always_comb begin
        section_next          = section_reg;
        header_phase_next     = header_phase_reg;
        header_key_next       = header_key_reg;
        number_value_next     = number_value_reg;
        number_seen_next      = number_seen_reg;
        default_duration_next = default_duration_reg;
        default_octave_next   = default_octave_reg;
        tempo_bpm_next        = tempo_bpm_reg;
        note_phase_next       = note_phase_reg;
        note_duration_next    = note_duration_reg;
        note_letter_next      = note_letter_reg;
        note_sharp_next       = note_sharp_reg;
        dot_count_next        = dot_count_reg;
        note_octave_next      = note_octave_reg;
        error_seen_next       = error_seen_reg;
        emit_note             = 1'b0;
        fail                  = 1'b0;
        do_start              = 1'b0;
        hp_cur                = header_phase_reg;
        lc                    = letter_code(s_ch);

        if (error_seen_reg) begin
            fail = 1'b1;
        end else if (section_reg == SEC_HEADER) begin
            if (s_ch == CH_NUL) begin
                fail = 1'b1;
            end else if (header_phase_reg == HP_VALUE) begin
                if (is_digit(s_ch)) begin
                    number_value_next = add_digit('0, s_ch);
                    number_seen_next  = 1'b1;
                    header_phase_next = HP_IN;
                end else if (!is_space(s_ch)) begin
                    error_seen_next = 1'b1;
                end
            end else if (header_phase_reg == HP_IN && is_digit(s_ch)) begin
                number_value_next = add_digit(number_value_reg, s_ch);
            end else begin
                // Close a finished value, then handle the character as a separator
                if (header_phase_reg == HP_IN) begin
                    if (header_key_reg == 8'h64 && number_value_reg != '0) begin
                        default_duration_next = number_value_reg;
                    end else if (header_key_reg == 8'h6F && number_value_reg <= NumW'(9)) begin
                        default_octave_next = number_value_reg[OctW-1:0];
                    end else if (header_key_reg == 8'h62 && number_value_reg != '0) begin
                        tempo_bpm_next = number_value_reg;
                    end
                    number_seen_next = 1'b0;
                    hp_cur           = HP_SKIP;
                end
                header_phase_next = hp_cur;
                if (s_ch == CH_COLON) begin
                    section_next    = SEC_NOTES;
                    note_phase_next = NP_DUR;
                end else if (hp_cur == HP_EQ) begin
                    if (!is_space(s_ch)) begin
                        header_phase_next = (s_ch == CH_EQ) ? HP_VALUE :
                                            (s_ch == CH_COMMA) ? HP_KEY : HP_SKIP;
                    end
                end else if (hp_cur == HP_KEY) begin
                    if (!is_space(s_ch) && s_ch != CH_COMMA) begin
                        header_key_next   = to_lower(s_ch);
                        header_phase_next = HP_EQ;
                    end
                end else if (s_ch == CH_COMMA) begin
                    header_phase_next = HP_KEY;
                end
            end
        end else if (section_reg == SEC_NOTES) begin
            case (note_phase_reg)
                NP_DUR: begin
                    if (is_digit(s_ch)) begin
                        number_value_next = add_digit('0, s_ch);
                        note_phase_next   = NP_DURNUM;
                    end else if (!is_space(s_ch) && s_ch != CH_COMMA) begin
                        note_duration_next = default_duration_reg;
                        do_start           = 1'b1;
                    end
                end
                NP_DURNUM: begin
                    if (is_digit(s_ch)) begin
                        number_value_next = add_digit(number_value_reg, s_ch);
                    end else begin
                        note_duration_next = (number_value_reg != '0) ? number_value_reg :
                                             default_duration_reg;
                        do_start = 1'b1;
                    end
                end
                NP_SHARP, NP_DOT: begin
                    if (note_phase_reg == NP_SHARP && s_ch == CH_HASH) begin
                        note_sharp_next = 1'b1;
                        note_phase_next = NP_DOT;
                    end else if (s_ch == CH_DOT) begin
                        if (dot_count_reg != 8'hFF) dot_count_next = dot_count_reg + 8'd1;
                        note_phase_next = NP_DOT;
                    end else if (is_digit(s_ch)) begin
                        number_value_next = add_digit('0, s_ch);
                        note_phase_next   = NP_OCT;
                    end else begin
                        note_octave_next = default_octave_reg;
                        emit_note        = 1'b1;
                    end
                end
                NP_OCT: begin
                    if (is_digit(s_ch)) begin
                        number_value_next = add_digit(number_value_reg, s_ch);
                    end else begin
                        note_octave_next = (number_value_reg <= NumW'(9)) ?
                                           number_value_reg[OctW-1:0] : default_octave_reg;
                        if (s_ch == CH_DOT) begin
                            if (dot_count_reg != 8'hFF) dot_count_next = dot_count_reg + 8'd1;
                            note_phase_next = NP_TDOT;
                        end else begin
                            emit_note = 1'b1;
                        end
                    end
                end
                NP_TDOT: begin
                    if (s_ch == CH_DOT) begin
                        if (dot_count_reg != 8'hFF) dot_count_next = dot_count_reg + 8'd1;
                    end else begin
                        emit_note = 1'b1;
                    end
                end
                default: begin
                    note_phase_next = (s_ch == CH_COMMA) ? NP_DUR : NP_SKIP;
                end
            endcase
            if (do_start) begin
                if (!lc.valid) begin
                    note_phase_next = (s_ch == CH_COMMA) ? NP_DUR : NP_SKIP;
                end else begin
                    note_letter_next = lc.code;
                    note_sharp_next  = 1'b0;
                    dot_count_next   = '0;
                    note_phase_next  = NP_SHARP;
                end
            end
            if (emit_note) begin
                note_phase_next = (s_ch == CH_COMMA) ? NP_DUR : NP_SKIP;
            end
        end else begin
            if (s_ch == CH_COLON) begin
                section_next      = SEC_HEADER;
                header_phase_next = HP_KEY;
            end else if (s_ch == CH_NUL) begin
                fail = 1'b1;
            end
        end
    end

    // Shared divider step: shift in one numerator bit, subtract when it fits
    logic [NumW:0]   div_sh;
    logic            div_fit;
    logic [NumW-1:0] div_rem_step;
    logic [DivW-1:0] div_num_step;

    always_comb begin
        div_sh       = {div_rem_reg, div_num_reg[DivW-1]};
        div_fit      = (div_sh >= {1'b0, div_den_reg});
        div_rem_step = div_fit ? NumW'(div_sh - {1'b0, div_den_reg}) : div_sh[NumW-1:0];
        div_num_step = {div_num_reg[DivW-2:0], div_fit};
    end

    // Build the note result from the work registers
    logic [NumW-1:0]  ms_cl;
    logic [3:0]       semi;
    logic [FreqW-1:0] f_base;
    logic [FreqW-1:0] f_sh;
    logic [FreqW-1:0] f_cl;
    logic             gap_on;

    always_comb begin
        if (ms_reg == '0) begin
            ms_cl = NumW'(1);
        end else if (ms_reg > (DivW+1)'(65535)) begin
            ms_cl = {NumW{1'b1}};
        end else begin
            ms_cl = ms_reg[NumW-1:0];
        end
        semi = letter_semitone(w_letter_reg);
        if (w_sharp_reg && semi < 4'd11) semi = semi + 4'd1;
        f_base = FreqW'(base_freq(semi));
        if (w_oct_reg > OctW'(4)) begin
            f_sh = f_base << (w_oct_reg - OctW'(4));
        end else begin
            f_sh = f_base >> (OctW'(4) - w_oct_reg);
        end
        if (f_sh > FreqMax) begin
            f_cl = FreqMax;
        end else if (f_sh == '0) begin
            f_cl = FreqW'(1);
        end else begin
            f_cl = f_sh;
        end
        gap_on = (note_gap_reg != '0) &&
                 ({1'b0, ms_cl} > ({1'b0, note_gap_reg} + (NumW+1)'(1)));
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (emit_note) state_next = S_DIV1;
                    else if (s_ch == CH_NUL) state_next = S_PUTF;
                end
            end
            S_DIV1:  if (div_cnt_reg == DivCntW'(1)) state_next = S_DIV2;
            S_DIV2:  if (div_cnt_reg == DivCntW'(1)) state_next = S_DOTS;
            S_DOTS:  if (w_dots_reg == '0 || ext_reg == '0) state_next = S_PUTN;
            S_PUTN:  if (slot_free) state_next = fin_pend_reg ? S_PUTF : S_IDLE;
            S_PUTF:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state; clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            fin_pend_reg <= 1'b0;
            note_gap_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                note_gap_reg <= pwdata[NumW-1:0];
            end
            if (accept) begin
                fin_pend_reg <= (s_ch == CH_NUL);
            end
            if (state_reg == S_PUTN || state_reg == S_PUTF) begin
                if (slot_free) m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Advance the parser state on each accepted character; an accepted NUL restores the start state
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_ch == CH_NUL)) begin
            section_reg          <= SEC_NAME;
            header_phase_reg     <= HP_KEY;
            header_key_reg       <= '0;
            number_value_reg     <= '0;
            number_seen_reg      <= 1'b0;
            default_duration_reg <= DefDuration;
            default_octave_reg   <= DefOctave;
            tempo_bpm_reg        <= DefTempo;
            note_phase_reg       <= NP_DUR;
            note_duration_reg    <= '0;
            note_letter_reg      <= '0;
            note_sharp_reg       <= 1'b0;
            dot_count_reg        <= '0;
            note_octave_reg      <= '0;
            error_seen_reg       <= 1'b0;
        end else if (accept) begin
            section_reg          <= section_next;
            header_phase_reg     <= header_phase_next;
            header_key_reg       <= header_key_next;
            number_value_reg     <= number_value_next;
            number_seen_reg      <= number_seen_next;
            default_duration_reg <= default_duration_next;
            default_octave_reg   <= default_octave_next;
            tempo_bpm_reg        <= tempo_bpm_next;
            note_phase_reg       <= note_phase_next;
            note_duration_reg    <= note_duration_next;
            note_letter_reg      <= note_letter_next;
            note_sharp_reg       <= note_sharp_next;
            dot_count_reg        <= dot_count_next;
            note_octave_reg      <= note_octave_next;
            error_seen_reg       <= error_seen_next;
        end
    end

    // Work registers: snapshot the note, run the divider and the dot additions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    div_cnt_reg <= '0;
                    if (accept) begin
                        w_dur_reg    <= (note_duration_next != '0) ? note_duration_next :
                                        NumW'(1);
                        w_letter_reg <= note_letter_next;
                        w_sharp_reg  <= note_sharp_next;
                        w_oct_reg    <= note_octave_next;
                        w_dots_reg   <= dot_count_next;
                        fin_fail_reg <= fail;
                        div_num_reg  <= MsPerMinute4;
                        div_rem_reg  <= '0;
                        div_den_reg  <= (tempo_bpm_reg != '0) ? tempo_bpm_reg : NumW'(1);
                        if (emit_note) div_cnt_reg <= DivSteps;
                    end
                end
                S_DIV1: begin
                    if (div_cnt_reg == DivCntW'(1)) begin
                        div_num_reg <= div_num_step;
                        div_rem_reg <= '0;
                        div_den_reg <= w_dur_reg;
                        div_cnt_reg <= DivSteps;
                    end else begin
                        div_num_reg <= div_num_step;
                        div_rem_reg <= div_rem_step;
                        div_cnt_reg <= div_cnt_reg - DivCntW'(1);
                    end
                end
                S_DIV2: begin
                    div_num_reg <= div_num_step;
                    div_rem_reg <= div_rem_step;
                    div_cnt_reg <= div_cnt_reg - DivCntW'(1);
                    if (div_cnt_reg == DivCntW'(1)) begin
                        ms_reg  <= {1'b0, div_num_step};
                        ext_reg <= {1'b0, div_num_step[DivW-1:1]};
                    end
                end
                S_DOTS: begin
                    if (w_dots_reg != '0 && ext_reg != '0) begin
                        ms_reg     <= ms_reg + {1'b0, ext_reg};
                        ext_reg    <= {1'b0, ext_reg[DivW-1:1]};
                        w_dots_reg <= w_dots_reg - 8'd1;
                    end
                end
                default: div_cnt_reg <= '0;
            endcase
        end
    end

    // Load the result register when the slot is free
    always_ff @(posedge aclk) begin
        if (state_reg == S_PUTN && slot_free) begin
            m_last_reg <= 1'b0;
            if (w_letter_reg == LETTER_P) begin
                m_kind_reg <= KIND_PAUSE;
                m_freq_reg <= '0;
                m_tone_reg <= ms_cl;
                m_gap_reg  <= '0;
            end else begin
                m_kind_reg <= KIND_TONE;
                m_freq_reg <= f_cl;
                m_tone_reg <= gap_on ? ms_cl - note_gap_reg : ms_cl;
                m_gap_reg  <= gap_on ? note_gap_reg : '0;
            end
        end else if (state_reg == S_PUTF && slot_free) begin
            m_last_reg <= 1'b1;
            m_kind_reg <= fin_fail_reg ? KIND_ERR : KIND_OK;
            m_freq_reg <= '0;
            m_tone_reg <= '0;
            m_gap_reg  <= '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_frequency_hz = m_freq_reg;
    assign m_tone_ms      = m_tone_reg;
    assign m_gap_ms       = m_gap_reg;
    assign m_last         = m_last_reg;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == 1'b0) ? {16'h0000, note_gap_reg} : 32'h0000_0000;

    // Checks
    a_last_is_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_kind[1])
        else $error("finish flag on a note result");

    a_note_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !m_kind[1])
        else $error("finish kind without finish flag");

    a_tone_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_TONE |-> m_frequency_hz != '0 && m_frequency_hz <= FreqMax)
        else $error("tone frequency out of range");

    a_silent_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_TONE |-> m_frequency_hz == '0 && m_gap_ms == '0)
        else $error("pause or finish carries frequency or gap");

    a_div_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cnt_reg != '0 |-> state_reg == S_DIV1 || state_reg == S_DIV2)
        else $error("divider counting outside divide states");

endmodule

FILE: test/rtttl_melody_parser_core_tb.sv
// Self-checking testbench for the RTTTL melody parser core: directed texts, random melodies.
module rtttl_melody_parser_core_tb;
    import rtttl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned SettleCycles = 80;

    typedef struct packed {
        logic [1:0]       kind;
        logic [FreqW-1:0] freq;
        logic [NumW-1:0]  tone;
        logic [NumW-1:0]  gap;
        logic             last;
    } note_res_t;

    typedef struct {
        string      text;
        bit         chk;
        logic [1:0] fin_kind;
    } text_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ChW-1:0]      s_ch = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_kind;
    logic [FreqW-1:0]    m_frequency_hz;
    logic [NumW-1:0]     m_tone_ms;
    logic [NumW-1:0]     m_gap_ms;
    logic                m_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    rtttl_melody_parser_core i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predicted parser state
    logic [NumW-1:0] gap_cfg;
    logic [1:0]      p_section;
    logic [2:0]      p_hphase, p_nphase, p_letter;
    logic [7:0]      p_hkey, p_dots;
    logic [NumW-1:0] p_num, p_def_dur, p_tempo, p_dur;
    logic [OctW-1:0] p_def_oct, p_oct;
    logic            p_sharp, p_err;

    note_res_t    pending_notes[$];
    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    byte unsigned txt_q[$];
    int unsigned  burst_left = 0;

    task automatic report(input string what, input note_res_t got, input note_res_t want);
        errors++;
        $display("MISMATCH %s: got k%0d f%0d t%0d g%0d l%0d, want k%0d f%0d t%0d g%0d l%0d",
                 what, got.kind, got.freq, got.tone, got.gap, got.last,
                 want.kind, want.freq, want.tone, want.gap, want.last);
    endtask

    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [NumW-1:0] push_digit(input logic [NumW-1:0] v,
                                                   input logic [7:0] c);
        int unsigned r;
        r = v * 10 + (c - 8'h30);
        return (r > 65535) ? 16'hFFFF : r[NumW-1:0];
    endfunction

    function automatic void parser_init();
        p_section = SEC_NAME; p_hphase = HP_KEY; p_hkey = '0; p_num = '0;
        p_def_dur = 16'd4; p_def_oct = 4'd6; p_tempo = 16'd140;
        p_nphase = NP_DUR; p_dur = '0; p_letter = '0; p_sharp = 1'b0;
        p_dots = '0; p_oct = '0; p_err = 1'b0;
    endfunction

    // Work out the tone or pause that closes the current note
    function automatic note_res_t note_result();
        int unsigned bpm, dur, ms, ext, semi, f, g, tn;
        int unsigned semis[7] = '{0, 2, 4, 5, 7, 9, 11};
        int unsigned freqs[12] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494};
        note_res_t r;
        bpm = p_tempo ? p_tempo : 1;
        dur = p_dur ? p_dur : 1;
        ms = (240000 / bpm) / dur;
        ext = ms / 2;
        for (int i = 0; i < p_dots && ext > 0; i++) begin
            ms += ext;
            ext /= 2;
        end
        if (ms == 0) ms = 1;
        else if (ms > 65535) ms = 65535;
        r = '0;
        if (p_letter == LETTER_P) begin
            r.kind = KIND_PAUSE;
            r.tone = ms[15:0];
            return r;
        end
        semi = semis[p_letter];
        if (p_sharp && semi < 11) semi++;
        f = freqs[semi];
        if (p_oct > 4) f = f << (p_oct - 4);
        else f = f >> (4 - p_oct);
        if (f > 20000) f = 20000;
        else if (f == 0) f = 1;
        g = 0;
        tn = ms;
        if (gap_cfg > 0 && ms > gap_cfg + 1) begin
            g = gap_cfg;
            tn = ms - g;
        end
        r.kind = KIND_TONE;
        r.freq = f[FreqW-1:0];
        r.tone = tn[15:0];
        r.gap = g[15:0];
        return r;
    endfunction

    function automatic void header_char(input logic [7:0] c);
        if (p_hphase == HP_VALUE) begin
            if (blank(c)) return;
            if (numeral(c)) begin
                p_num = push_digit('0, c);
                p_hphase = HP_IN;
            end else p_err = 1'b1;
            return;
        end
        if (p_hphase == HP_IN) begin
            if (numeral(c)) begin
                p_num = push_digit(p_num, c);
                return;
            end
            if (p_hkey == 8'h64 && p_num > 0) p_def_dur = p_num;
            else if (p_hkey == 8'h6F && p_num <= 9) p_def_oct = p_num[3:0];
            else if (p_hkey == 8'h62 && p_num > 0) p_tempo = p_num;
            p_hphase = HP_SKIP;
        end
        if (c == CH_COLON) begin
            p_section = SEC_NOTES;
            p_nphase = NP_DUR;
            return;
        end
        if (p_hphase == HP_EQ) begin
            if (blank(c)) return;
            p_hphase = (c == CH_EQ) ? HP_VALUE : (c == CH_COMMA) ? HP_KEY : HP_SKIP;
            return;
        end
        if (p_hphase == HP_KEY) begin
            if (blank(c) || c == CH_COMMA) return;
            p_hkey = lc(c);
            p_hphase = HP_EQ;
            return;
        end
        if (c == CH_COMMA) p_hphase = HP_KEY;
    endfunction

    function automatic void open_note(input logic [7:0] c);
        int code;
        case (lc(c))
            8'h63: code = 0;
            8'h64: code = 1;
            8'h65: code = 2;
            8'h66: code = 3;
            8'h67: code = 4;
            8'h61: code = 5;
            8'h62: code = 6;
            8'h70: code = 7;
            default: code = -1;
        endcase
        if (code < 0) begin
            p_nphase = (c == CH_COMMA) ? NP_DUR : NP_SKIP;
            return;
        end
        p_letter = code[2:0];
        p_sharp = 1'b0;
        p_dots = '0;
        p_nphase = NP_SHARP;
    endfunction

    function automatic void add_dot();
        if (p_dots < 8'd255) p_dots++;
    endfunction

    // Returns 1 when the character closes a note
    function automatic bit notes_char(input logic [7:0] c);
        case (p_nphase)
            NP_DUR: begin
                if (blank(c) || c == CH_COMMA) return 0;
                if (numeral(c)) begin
                    p_num = push_digit('0, c);
                    p_nphase = NP_DURNUM;
                    return 0;
                end
                p_dur = p_def_dur;
                open_note(c);
                return 0;
            end
            NP_DURNUM: begin
                if (numeral(c)) begin
                    p_num = push_digit(p_num, c);
                    return 0;
                end
                p_dur = p_num > 0 ? p_num : p_def_dur;
                open_note(c);
                return 0;
            end
            NP_SHARP, NP_DOT: begin
                if (p_nphase == NP_SHARP && c == CH_HASH) begin
                    p_sharp = 1'b1;
                    p_nphase = NP_DOT;
                    return 0;
                end
                if (c == CH_DOT) begin
                    add_dot();
                    p_nphase = NP_DOT;
                    return 0;
                end
                if (numeral(c)) begin
                    p_num = push_digit('0, c);
                    p_nphase = NP_OCT;
                    return 0;
                end
                p_oct = p_def_oct;
            end
            NP_OCT: begin
                if (numeral(c)) begin
                    p_num = push_digit(p_num, c);
                    return 0;
                end
                p_oct = (p_num <= 9) ? p_num[3:0] : p_def_oct;
                if (c == CH_DOT) begin
                    add_dot();
                    p_nphase = NP_TDOT;
                    return 0;
                end
            end
            NP_TDOT: begin
                if (c == CH_DOT) begin
                    add_dot();
                    return 0;
                end
            end
            default: begin
                p_nphase = (c == CH_COMMA) ? NP_DUR : NP_SKIP;
                return 0;
            end
        endcase
        pending_notes.push_back(note_result());
        p_nphase = (c == CH_COMMA) ? NP_DUR : NP_SKIP;
        return 1;
    endfunction

    // Advance the predictor by one accepted character
    function automatic void predict_char(input logic [7:0] c);
        bit fail;
        bit dummy;
        note_res_t fin;
        fail = 1'b0;
        if (p_err) fail = 1'b1;
        else if (p_section == SEC_HEADER) begin
            if (c == CH_NUL) fail = 1'b1;
            else header_char(c);
        end else if (p_section == SEC_NOTES) dummy = notes_char(c);
        else if (c == CH_COLON) begin
            p_section = SEC_HEADER;
            p_hphase = HP_KEY;
        end else if (c == CH_NUL) fail = 1'b1;
        if (c == CH_NUL) begin
            fin = '0;
            fin.kind = fail ? KIND_ERR : KIND_OK;
            fin.last = 1'b1;
            pending_notes.push_back(fin);
            parser_init();
        end
    endfunction

    // Check each result transaction against the oldest prediction
    always @(posedge aclk) begin
        note_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_frequency_hz, m_tone_ms, m_gap_ms, m_last};
            if (pending_notes.size() == 0) report("unexpected result", got, '0);
            else if (got != pending_notes[0]) report("result", got, pending_notes.pop_front());
            else void'(pending_notes.pop_front());
        end
    end

    // Receiver stalls: always ready, light random, heavy random, by phase
    always @(negedge aclk) begin
        case ((cycles / 97) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 3) != 0;
            default: m_ready <= $urandom_range(0, 7) == 0;
        endcase
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Send one character, with bursty gaps on the sender side
    task automatic send_char(input logic [7:0] c);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge aclk);
        end
        burst_left--;
        s_valid = 1'b1;
        s_ch = c;
        do @(posedge aclk); while (!s_ready);
        predict_char(c);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_text();
        foreach (txt_q[i]) send_char(txt_q[i]);
    endtask

    // Hold until every predicted result has come, then let the core settle
    task automatic drain();
        while (pending_notes.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = {16'h0, v}; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        gap_cfg = v;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    function automatic byte unsigned pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void push_num(input int unsigned maxd);
        int unsigned n;
        n = $urandom_range(1, maxd);
        for (int i = 0; i < n; i++) txt_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endfunction

    // Build a random melody; some broken, some pure noise
    function automatic void build_melody();
        int unsigned style, nn;
        txt_q.delete();
        style = $urandom_range(0, 9);
        if (style == 0) begin
            nn = $urandom_range(1, 12);
            for (int i = 0; i < nn; i++) txt_q.push_back(8'($urandom_range(1, 255)));
            return;
        end
        nn = $urandom_range(0, 3);
        for (int i = 0; i < nn; i++) txt_q.push_back(pick("Song x1-"));
        txt_q.push_back(CH_COLON);
        nn = $urandom_range(0, 3);
        for (int i = 0; i < nn; i++) begin
            if ($urandom_range(0, 3) == 0) txt_q.push_back(CH_SPACE);
            txt_q.push_back(pick("dobDOBdobz"));
            if ($urandom_range(0, 9) != 0) txt_q.push_back(CH_EQ);
            if ($urandom_range(0, 5) == 0) txt_q.push_back(CH_SPACE);
            if (style == 1 && i == 0) txt_q.push_back(pick("x#-"));
            push_num($urandom_range(0, 7) == 0 ? 6 : 2);
            txt_q.push_back(CH_COMMA);
        end
        if (style == 2) return;
        txt_q.push_back(CH_COLON);
        nn = $urandom_range(1, 8);
        for (int i = 0; i < nn; i++) begin
            if ($urandom_range(0, 5) == 0) txt_q.push_back(CH_SPACE);
            if ($urandom_range(0, 1)) push_num($urandom_range(0, 9) == 0 ? 6 : 2);
            txt_q.push_back(pick("cdefgabpCDEFGABPcdegap"));
            if ($urandom_range(0, 3) == 0) txt_q.push_back(CH_HASH);
            if ($urandom_range(0, 4) == 0) txt_q.push_back(CH_DOT);
            if ($urandom_range(0, 1)) push_num($urandom_range(0, 9) == 0 ? 3 : 1);
            if ($urandom_range(0, 4) == 0) txt_q.push_back(CH_DOT);
            if ($urandom_range(0, 9) == 0) txt_q.push_back(8'($urandom_range(1, 255)));
            if (i + 1 < nn) txt_q.push_back(CH_COMMA);
        end
    endfunction

    text_row_t dir_rows[] = '{
        '{"", 1'b1, KIND_ERR},
        '{"abc", 1'b1, KIND_ERR},
        '{"x:d=4", 1'b1, KIND_ERR},
        '{"x:d=z:c,d", 1'b1, KIND_ERR},
        '{"x::c", 1'b1, KIND_OK},
        '{"t:d=0,o=12,b=0,q=5,zz,:8c#6,p,b#.,32a..9,65535e99999,4g,c.", 1'b1, KIND_OK},
        '{"T:D=8,O=5,B=999999:1c9,64c0,x,4 c,8P....,C4.", 1'b1, KIND_OK},
        '{"t:o=0,b=1, d = 1:1a,,2f#..,c,8", 1'b1, KIND_OK}
    };

    initial begin
        int unsigned sent;
        logic [15:0] gaps[4];
        gaps = '{16'd0, 16'd65535, 16'd1, 16'd50};
        parser_init();
        gap_cfg = '0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed texts, cycling through four gap settings
        foreach (dir_rows[r]) begin
            write_gap(gaps[r % 4]);
            txt_q.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++) txt_q.push_back(dir_rows[r].text[i]);
            send_text();
            send_char(CH_NUL);
            if (dir_rows[r].chk && pending_notes[$].kind != dir_rows[r].fin_kind)
                report("finish kind", pending_notes[$], '{dir_rows[r].fin_kind, 0, 0, 0, 1});
            drain();
        end

        // Dot count beyond saturation on a slow whole note
        write_gap(16'd20);
        txt_q.delete();
        begin
            string head;
            head = "s:b=1:1c";
            for (int i = 0; i < head.len(); i++) txt_q.push_back(head[i]);
            repeat (260) txt_q.push_back(CH_DOT);
        end
        send_text();
        send_char(CH_NUL);
        drain();

        // Random melodies, with config changes between some of them
        sent = 0;
        while (sent < 100) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: write_gap(16'd0);
                    1: write_gap(16'hFFFF);
                    2: write_gap(16'($urandom_range(1, 400)));
                    default: write_gap(16'($urandom_range(0, 65535)));
                endcase
            end
            build_melody();
            send_text();
            send_char(CH_NUL);
            sent += txt_q.size() + 1;
        end

        drain();
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/rtttl_pkg.sv
src/rtttl_melody_parser_core.sv
test/rtttl_melody_parser_core_tb.sv
